[rtl/core/qts_pkg.sv]
// shared types and constants for the quoted token scanner
`timescale 1ns / 1ps
`default_nettype none

package qts_pkg;

    // character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    // configuration register indexes
    localparam logic REG_RULE_SET = 1'b0;
    localparam logic REG_MAX_LEN  = 1'b1;

    // reset values of the configuration registers
    localparam logic        RULE_SET_RESET = 1'b0;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd256;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // classified item handed from front to back
    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
        logic       is_zero;
        logic       is_sep;
        logic       is_quote;
        logic       prev_bslash;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/core/quoted_token_scanner.sv]
// top level of the quoted token scanner: config registers, front, queue, back
// a character waits in the back end's one-character hold until the item that releases it
//   (the next token character, a separator, a quote or the line end), then leaves via the output register
// throughput: one item per cycle while results are taken, set by the token update in the back end
// reset: synchronous active low; control state clears at once, registers take defaults
//   (rule set 0, max length 256), no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module quoted_token_scanner #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input items
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] ch
    input  wire logic        i_s_axis_tlast,   // line_end
    // result items
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [7:0] out_char
    output logic             o_m_axis_tlast,   // token_last
    output logic [3:0]       o_m_axis_tuser,   // [0] token_first [1] token_empty
                                               // [2] was_quoted [3] too_long
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic          r_rule_set;
    logic [15:0]   r_max_len;
    logic          cfg_write;
    logic          q_full;
    logic          q_push;
    logic          q_valid;
    logic          q_pop;
    qts_pkg::t_cmd f_cmd;
    qts_pkg::t_cmd b_cmd;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_set <= qts_pkg::RULE_SET_RESET;
            r_max_len  <= qts_pkg::MAX_LEN_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                qts_pkg::REG_RULE_SET: r_rule_set <= pwdata[0];
                qts_pkg::REG_MAX_LEN:  r_max_len  <= pwdata[15:0];
                default:               r_rule_set <= r_rule_set;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[2])
            qts_pkg::REG_RULE_SET: prdata = {31'd0, r_rule_set};
            qts_pkg::REG_MAX_LEN:  prdata = {16'd0, r_max_len};
            default:               prdata = 32'd0;
        endcase
    end

    qts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_ch       (i_s_axis_tdata),
        .i_line_end (i_s_axis_tlast),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_cmd    (f_cmd)
    );

    qts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (b_cmd)
    );

    qts_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rule_set (r_rule_set),
        .i_max_len  (r_max_len),
        .i_q_valid  (q_valid),
        .i_q_cmd    (b_cmd),
        .o_q_pop    (q_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_char     (o_m_axis_tdata),
        .o_first    (o_m_axis_tuser[0]),
        .o_last     (o_m_axis_tlast),
        .o_empty    (o_m_axis_tuser[1]),
        .o_quoted   (o_m_axis_tuser[2]),
        .o_too_long (o_m_axis_tuser[3])
    );

endmodule

`default_nettype wire

[rtl/core/qts_front.sv]
// front end: accepts characters, tracks line context and classifies each item
`timescale 1ns / 1ps
`default_nettype none

module qts_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_ch,
    input  wire logic          i_line_end,
    input  wire logic          i_q_full,
    output logic               o_q_push,
    output qts_pkg::t_cmd      o_q_cmd
);

    logic [7:0] r_prev;
    logic [7:0] n_prev;
    logic       r_ended;
    logic       n_ended;
    logic       accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    // classification of the incoming character
    always_comb begin
        o_q_cmd.ch          = i_ch;
        o_q_cmd.line_end    = i_line_end;
        o_q_cmd.is_zero     = (i_ch == 8'd0);
        o_q_cmd.is_sep      = (i_ch == qts_pkg::CH_SPACE) ||
                              ((i_ch >= qts_pkg::CH_TAB) && (i_ch <= qts_pkg::CH_CR)) ||
                              (i_ch == qts_pkg::CH_COMMA) || (i_ch == qts_pkg::CH_SEMI);
        o_q_cmd.is_quote    = (i_ch == qts_pkg::CH_QUOTE);
        o_q_cmd.prev_bslash = (r_prev == qts_pkg::CH_BSLASH);
    end

    // characters after a zero carry nothing until the line ends
    assign o_q_push = accept && (i_line_end || !r_ended);

    // line context: previous character and end-of-data mark
    always_comb begin
        n_prev  = r_prev;
        n_ended = r_ended;
        if (accept) begin
            if (i_line_end) begin
                n_prev  = 8'd0;
                n_ended = 1'b0;
            end else if (!r_ended) begin
                if (i_ch == 8'd0) begin
                    n_prev  = 8'd0;
                    n_ended = 1'b1;
                end else begin
                    n_prev = i_ch;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 8'd0;
            r_ended <= 1'b0;
        end else begin
            r_prev  <= n_prev;
            r_ended <= n_ended;
        end
    end

endmodule

`default_nettype wire

[rtl/core/qts_queue.sv]
// short queue of classified items between front and back
`timescale 1ns / 1ps
`default_nettype none

module qts_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire qts_pkg::t_cmd i_cmd,
    output logic               o_full,
    output logic               o_valid,
    input  wire logic          i_pop,
    output qts_pkg::t_cmd      o_cmd
);

    qts_pkg::t_cmd r_mem [qts_pkg::QUEUE_DEPTH];
    logic [qts_pkg::QUEUE_PTR_W-1:0] r_wptr;
    logic [qts_pkg::QUEUE_PTR_W-1:0] r_rptr;
    logic [qts_pkg::QUEUE_CNT_W-1:0] r_count;
    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == qts_pkg::QUEUE_CNT_W'(qts_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/qts_back.sv]
// back end: token state machine with one-character hold and output register
`timescale 1ns / 1ps
`default_nettype none

module qts_back #(
    parameter int LENGTH_BITS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rule_set,
    input  wire logic [15:0]   i_max_len,
    input  wire logic          i_q_valid,
    input  wire qts_pkg::t_cmd i_q_cmd,
    output logic               o_q_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [7:0]         o_char,
    output logic               o_first,
    output logic               o_last,
    output logic               o_empty,
    output logic               o_quoted,
    output logic               o_too_long
);

    localparam int CMP_W = ((LENGTH_BITS > 16) ? LENGTH_BITS : 16) + 1;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PLAIN,
        MODE_INNER,
        MODE_QUOTED
    } t_mode;

    t_mode                  r_mode;
    t_mode                  n_mode;
    t_mode                  mode_eff;
    logic [7:0]             r_held;
    logic [7:0]             n_held;
    logic                   r_held_valid;
    logic                   n_held_valid;
    logic                   r_held_first;
    logic                   n_held_first;
    logic [LENGTH_BITS-1:0] r_len;
    logic [LENGTH_BITS-1:0] n_len;

    logic                   r_out_valid;
    logic [7:0]             r_char;
    logic                   r_first;
    logic                   r_last;
    logic                   r_empty;
    logic                   r_quoted;
    logic                   r_too_long;

    logic                   issue;
    logic                   emit;
    logic [7:0]             e_char;
    logic                   e_first;
    logic                   e_last;
    logic                   e_empty;
    logic                   e_quoted;
    logic                   e_too_long;
    logic                   in_token;
    logic                   open_quote;
    logic                   too_long;
    logic                   do_push;
    logic                   do_finish;
    logic [LENGTH_BITS-1:0] len_base;

    assign issue   = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop = issue;

    assign in_token   = (r_mode != MODE_IDLE);
    assign mode_eff   = (i_rule_set && (r_mode == MODE_INNER)) ? MODE_PLAIN : r_mode;
    assign open_quote = i_q_cmd.is_quote && (i_rule_set || !i_q_cmd.prev_bslash);
    assign too_long   = i_rule_set &&
                        ((CMP_W'(r_len) + CMP_W'(1)) > CMP_W'(i_max_len));

    // decide what the item does to the token
    always_comb begin
        n_mode    = r_mode;
        do_push   = 1'b0;
        do_finish = 1'b0;
        len_base  = r_len;
        if (i_q_cmd.line_end || i_q_cmd.is_zero) begin
            do_finish = in_token;
            n_mode    = MODE_IDLE;
        end else begin
            case (mode_eff)
                MODE_IDLE: begin
                    if (!i_q_cmd.is_sep) begin
                        len_base = '0;
                        if (i_q_cmd.is_quote) begin
                            n_mode = MODE_QUOTED;
                        end else begin
                            n_mode  = MODE_PLAIN;
                            do_push = 1'b1;
                        end
                    end
                end
                MODE_PLAIN: begin
                    n_mode = MODE_PLAIN;
                    if (i_q_cmd.is_sep) begin
                        do_finish = 1'b1;
                        n_mode    = MODE_IDLE;
                    end else begin
                        do_push = 1'b1;
                        if (!i_rule_set && open_quote) begin
                            n_mode = MODE_INNER;
                        end
                    end
                end
                MODE_INNER: begin
                    do_push = 1'b1;
                    if (open_quote) begin
                        n_mode = MODE_PLAIN;
                    end
                end
                MODE_QUOTED: begin
                    if (open_quote) begin
                        do_finish = 1'b1;
                        n_mode    = MODE_IDLE;
                    end else begin
                        do_push = 1'b1;
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
        end
    end

    // result of the item and next hold contents
    always_comb begin
        emit         = 1'b0;
        e_char       = r_held;
        e_first      = r_held_first;
        e_last       = 1'b0;
        e_empty      = 1'b0;
        e_quoted     = (mode_eff == MODE_QUOTED);
        e_too_long   = 1'b0;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_held_first = r_held_first;
        n_len        = len_base;
        if (do_finish) begin
            e_quoted   = (r_mode == MODE_QUOTED);
            e_last     = 1'b1;
            e_too_long = too_long;
            if (r_held_valid) begin
                emit = 1'b1;
            end else if (r_mode == MODE_QUOTED) begin
                emit    = 1'b1;
                e_char  = 8'd0;
                e_first = 1'b1;
                e_empty = 1'b1;
            end
            n_held       = 8'd0;
            n_held_valid = 1'b0;
            n_held_first = 1'b0;
        end else if (do_push) begin
            emit         = r_held_valid && (mode_eff != MODE_IDLE);
            n_held_first = !(r_held_valid && (mode_eff != MODE_IDLE));
            n_held_valid = 1'b1;
            n_held       = i_q_cmd.ch;
            if (len_base != '1) begin
                n_len = len_base + 1'b1;
            end
        end
    end

    // token state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_IDLE;
            r_held       <= 8'd0;
            r_held_valid <= 1'b0;
            r_held_first <= 1'b0;
            r_len        <= '0;
            r_out_valid  <= 1'b0;
            r_char       <= 8'd0;
            r_first      <= 1'b0;
            r_last       <= 1'b0;
            r_empty      <= 1'b0;
            r_quoted     <= 1'b0;
            r_too_long   <= 1'b0;
        end else begin
            if (issue) begin
                r_mode       <= n_mode;
                r_held       <= n_held;
                r_held_valid <= n_held_valid;
                r_held_first <= n_held_first;
                r_len        <= n_len;
            end
            if (issue && emit) begin
                r_out_valid <= 1'b1;
                r_char      <= e_char;
                r_first     <= e_first;
                r_last      <= e_last;
                r_empty     <= e_empty;
                r_quoted    <= e_quoted;
                r_too_long  <= e_too_long;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_char     = r_char;
    assign o_first    = r_first;
    assign o_last     = r_last;
    assign o_empty    = r_empty;
    assign o_quoted   = r_quoted;
    assign o_too_long = r_too_long;

    // between tokens nothing is held
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_IDLE) |-> !r_held_valid)
        else $error("character held outside a token");

    // an empty token is a whole quoted token by itself
    a_empty_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_empty) |-> (r_first && r_last && r_quoted))
        else $error("empty mark on a partial token");

    // the length flag only rides on the last result
    a_too_long_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_too_long) |-> r_last)
        else $error("length flag before the last result");

    // no item is taken while a result waits and cannot leave
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && r_out_valid) |-> i_ready)
        else $error("item issued over a waiting result");

endmodule

`default_nettype wire

[bench/quoted_token_scanner_tb.sv]
// self-checking bench for the quoted token scanner: random lines, idling, back-pressure
`timescale 1ns / 1ps

module quoted_token_scanner_tb;

    localparam int LENGTH_BITS = 16;
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 8;
    localparam int LONG_TOKEN  = 300;
    localparam int PHASE_ITEMS = 200;

    localparam logic [2:0] ADDR_RULE = {qts_pkg::REG_RULE_SET, 2'b00};
    localparam logic [2:0] ADDR_LEN  = {qts_pkg::REG_MAX_LEN, 2'b00};

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_PLAIN, SCAN_INNER, SCAN_QUOTED, SCAN_ENDED
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } t_line_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       first;
        logic       last;
        logic       empty;
        logic       quoted;
        logic       too_long;
    } t_token_char;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // block ports
    logic        s_valid = 1'b0;
    logic [7:0]  s_data  = 8'h00;
    logic        s_last  = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_data;
    logic        m_last;
    logic [3:0]  m_user;
    logic        apb_sel    = 1'b0;
    logic        apb_enable = 1'b0;
    logic        apb_write  = 1'b0;
    logic [2:0]  apb_addr   = 3'd0;
    logic [31:0] apb_wdata  = 32'd0;
    logic [31:0] apb_rdata;
    logic        apb_ready;

    quoted_token_scanner #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tlast (s_last),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data),
        .o_m_axis_tlast (m_last),
        .o_m_axis_tuser (m_user),
        .psel           (apb_sel),
        .penable        (apb_enable),
        .pwrite         (apb_write),
        .paddr          (apb_addr),
        .pwdata         (apb_wdata),
        .prdata         (apb_rdata),
        .pready         (apb_ready)
    );

    // stimulus and expectation stores
    t_line_item  chars_to_send[$];
    t_token_char tokens_due[$];

    int errors      = 0;
    int items_made  = 0;
    int items_in    = 0;
    int chars_out   = 0;
    int settings    = 0;
    bit idle_in     = 1'b1;
    bit idle_out    = 1'b1;
    bit hold_arm    = 1'b0;
    bit in_took     = 1'b0;
    bit out_took    = 1'b0;
    int in_gap      = 0;
    int out_gap     = 0;
    int hold_left   = 0;
    bit hold_seen   = 1'b0;

    // scanner shadow: registers and token state
    logic                   rules_sh   = qts_pkg::RULE_SET_RESET;
    logic [15:0]            max_len_sh = qts_pkg::MAX_LEN_RESET;
    t_scan_mode             mode       = SCAN_IDLE;
    logic [7:0]             prev_ch    = 8'h00;
    logic [7:0]             held_ch    = 8'h00;
    logic                   held_ok    = 1'b0;
    logic                   held_first = 1'b0;
    logic [LENGTH_BITS-1:0] tok_len    = '0;

    function automatic bit separates(logic [7:0] c);
        return c == qts_pkg::CH_SPACE ||
               (c >= qts_pkg::CH_TAB && c <= qts_pkg::CH_CR) ||
               c == qts_pkg::CH_COMMA || c == qts_pkg::CH_SEMI;
    endfunction

    function automatic bit mid_token();
        return mode == SCAN_PLAIN || mode == SCAN_INNER || mode == SCAN_QUOTED;
    endfunction

    function automatic string show(t_token_char t);
        return $sformatf("char=%02h f=%b l=%b e=%b q=%b t=%b",
                         t.ch, t.first, t.last, t.empty, t.quoted, t.too_long);
    endfunction

    // end of token: release the held character with the last mark
    task automatic close_token();
        t_token_char r;
        logic        quoted;
        logic        long_flag;
        quoted    = (mode == SCAN_QUOTED);
        long_flag = rules_sh && ({1'b0, tok_len} + 1 > {1'b0, max_len_sh});
        if (held_ok) begin
            r = '{held_ch, held_first, 1'b1, 1'b0, quoted, long_flag};
            tokens_due.push_back(r);
        end else if (quoted) begin
            r = '{8'h00, 1'b1, 1'b1, 1'b1, 1'b1, long_flag};
            tokens_due.push_back(r);
        end
        held_ok    = 1'b0;
        held_first = 1'b0;
        held_ch    = 8'h00;
    endtask

    // token character: the previously held one goes out, this one is held
    task automatic take_char(logic [7:0] c);
        t_token_char r;
        if (held_ok) begin
            r = '{held_ch, held_first, 1'b0, 1'b0, mode == SCAN_QUOTED, 1'b0};
            tokens_due.push_back(r);
        end
        held_first = !held_ok;
        held_ok    = 1'b1;
        held_ch    = c;
        if (tok_len != '1)
            tok_len = tok_len + 1'b1;
    endtask

    // predicted token output for one accepted character
    task automatic scan_step(logic [7:0] c, logic line_end);
        logic opens;
        if (line_end) begin
            if (mid_token())
                close_token();
            mode    = SCAN_IDLE;
            prev_ch = 8'h00;
        end else if (mode == SCAN_ENDED) begin
            // rest of the line after a zero is dropped
        end else if (c == 8'h00) begin
            if (mid_token())
                close_token();
            mode    = SCAN_ENDED;
            prev_ch = 8'h00;
        end else begin
            if (rules_sh && mode == SCAN_INNER)
                mode = SCAN_PLAIN;
            opens = (c == qts_pkg::CH_QUOTE) && (rules_sh || prev_ch != qts_pkg::CH_BSLASH);
            case (mode)
                SCAN_IDLE: begin
                    if (!separates(c)) begin
                        tok_len = '0;
                        held_ok = 1'b0;
                        if (c == qts_pkg::CH_QUOTE) begin
                            mode = SCAN_QUOTED;
                        end else begin
                            mode = SCAN_PLAIN;
                            take_char(c);
                        end
                    end
                end
                SCAN_PLAIN: begin
                    if (separates(c)) begin
                        close_token();
                        mode = SCAN_IDLE;
                    end else begin
                        take_char(c);
                        if (!rules_sh && opens)
                            mode = SCAN_INNER;
                    end
                end
                SCAN_INNER: begin
                    take_char(c);
                    if (opens)
                        mode = SCAN_PLAIN;
                end
                SCAN_QUOTED: begin
                    if (opens) begin
                        close_token();
                        mode = SCAN_IDLE;
                    end else begin
                        take_char(c);
                    end
                end
                default: mode = SCAN_IDLE;
            endcase
            prev_ch = c;
        end
    endtask

    // compare one result item against the oldest expectation
    task automatic check_token_char();
        t_token_char want;
        t_token_char got;
        got = '{m_data, m_user[0], m_last, m_user[1], m_user[2], m_user[3]};
        chars_out++;
        if (tokens_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual %s", $time, show(got));
        end else begin
            want = tokens_due.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch expected %s, actual %s",
                         $time, show(want), show(got));
            end
        end
    endtask

    // sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        in_took  = i_rst_n && s_valid && s_ready;
        out_took = i_rst_n && m_valid && m_ready;
        if (out_took)
            check_token_char();
        if (in_took) begin
            items_in++;
            scan_step(s_data, s_last);
        end
    end

    // long hold-off counter, started once each time it is armed
    always @(posedge i_clk) begin
        if (hold_arm && !hold_seen)
            hold_left = LONG_HOLD;
        else if (hold_left > 0)
            hold_left--;
        hold_seen = hold_arm;
    end

    // sender: one item at a time from the pending queue, random gap after each when input gaps are on
    always @(negedge i_clk) begin
        t_line_item nxt;
        bit         load;
        load = 1'b0;
        if (s_valid && in_took)
            in_gap = idle_in ? $urandom_range(0, 9) : 0;
        if (!s_valid || in_took) begin
            if (in_gap > 0)
                in_gap--;
            else if (chars_to_send.size() > 0)
                load = 1'b1;
        end
        if (load) begin
            nxt = chars_to_send.pop_front();
            s_valid <= 1'b1;
            s_data  <= nxt.ch;
            s_last  <= nxt.line_end;
        end else if (!s_valid || in_took) begin
            s_valid <= 1'b0;
        end
    end

    // receiver: random stall per item when output gaps are on, held off while the long hold runs
    always @(negedge i_clk) begin
        if (out_took)
            out_gap = idle_out ? $urandom_range(0, 9) : 0;
        if (hold_left > 0) begin
            m_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // register access
    task automatic apb_put(logic [2:0] addr, logic [31:0] data);
        @(negedge i_clk);
        apb_sel   = 1'b1;
        apb_write = 1'b1;
        apb_addr  = addr;
        apb_wdata = data;
        @(negedge i_clk);
        apb_enable = 1'b1;
        do @(posedge i_clk); while (!apb_ready);
        @(negedge i_clk);
        apb_sel    = 1'b0;
        apb_enable = 1'b0;
        apb_write  = 1'b0;
    endtask

    task automatic apb_check(logic [2:0] addr, logic [31:0] want);
        logic [31:0] got;
        @(negedge i_clk);
        apb_sel   = 1'b1;
        apb_write = 1'b0;
        apb_addr  = addr;
        @(negedge i_clk);
        apb_enable = 1'b1;
        do @(posedge i_clk); while (!apb_ready);
        got = apb_rdata;
        @(negedge i_clk);
        apb_sel    = 1'b0;
        apb_enable = 1'b0;
        if (got !== want) begin
            errors++;
            $display("%0t: register read at %0d expected %08h actual %08h",
                     $time, addr, want, got);
        end
    endtask

    // write both registers with junk in the unused bits, then read them back
    task automatic set_rules(logic rules, logic [15:0] len);
        logic [31:0] word;
        word    = $urandom();
        word[0] = rules;
        apb_put(ADDR_RULE, word);
        word       = $urandom();
        word[15:0] = len;
        apb_put(ADDR_LEN, word);
        rules_sh   = rules;
        max_len_sh = len;
        apb_check(ADDR_RULE, {31'd0, rules});
        apb_check(ADDR_LEN, {16'd0, len});
        settings++;
    endtask

    // wait until everything sent has been accepted and every result has come
    task automatic drain();
        while (chars_to_send.size() > 0 || s_valid)
            @(posedge i_clk);
        while (tokens_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic queue_item(logic [7:0] c, logic line_end);
        chars_to_send.push_back('{c, line_end});
        items_made++;
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (separates(c) || c == qts_pkg::CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] sep_char();
        case ($urandom_range(0, 5))
            0: return qts_pkg::CH_SPACE;
            1: return qts_pkg::CH_COMMA;
            2: return qts_pkg::CH_SEMI;
            3: return qts_pkg::CH_TAB;
            4: return qts_pkg::CH_CR;
            default: return 8'($urandom_range(9, 13));
        endcase
    endfunction

    function automatic logic [7:0] mixed_char();
        case ($urandom_range(0, 7))
            0: return sep_char();
            1: return qts_pkg::CH_BSLASH;
            default: return word_char();
        endcase
    endfunction

    // one random line: mostly well-formed tokens, sometimes noise
    task automatic gen_line();
        int n_tok;
        int len;
        int pick;
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 8);
            repeat (len) queue_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            return;
        end
        if ($urandom_range(0, 2) == 0)
            queue_item(sep_char(), 1'b0);
        n_tok = $urandom_range(0, 5);
        repeat (n_tok) begin
            if ($urandom_range(0, 9) < 5) begin
                // unquoted word, sometimes with an embedded quoted section
                len = $urandom_range(1, 6);
                repeat (len) queue_item(word_char(), 1'b0);
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 3) == 0)
                        queue_item(qts_pkg::CH_BSLASH, 1'b0);
                    queue_item(qts_pkg::CH_QUOTE, 1'b0);
                    len = $urandom_range(0, 4);
                    repeat (len) queue_item(mixed_char(), 1'b0);
                    if ($urandom_range(0, 4) != 0)
                        queue_item(qts_pkg::CH_QUOTE, 1'b0);
                    len = $urandom_range(0, 2);
                    repeat (len) queue_item(word_char(), 1'b0);
                end
            end else begin
                // quoted token, with escaped quotes, sometimes left open
                queue_item(qts_pkg::CH_QUOTE, 1'b0);
                len = $urandom_range(0, 6);
                repeat (len) begin
                    if ($urandom_range(0, 5) == 0) begin
                        queue_item(qts_pkg::CH_BSLASH, 1'b0);
                        queue_item(qts_pkg::CH_QUOTE, 1'b0);
                    end else begin
                        queue_item(mixed_char(), 1'b0);
                    end
                end
                if ($urandom_range(0, 7) != 0)
                    queue_item(qts_pkg::CH_QUOTE, 1'b0);
            end
            len = $urandom_range(0, 2);
            repeat (len) queue_item(sep_char(), 1'b0);
        end
        pick = $urandom_range(0, 19);
        if (pick < 17) begin
            queue_item(8'($urandom_range(0, 255)), 1'b1);
        end else if (pick < 19) begin
            queue_item(8'h00, 1'b0);
            len = $urandom_range(0, 3);
            repeat (len) queue_item(8'($urandom_range(0, 255)), 1'b0);
            queue_item(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    task automatic run_phase(logic rules, logic [15:0] len, bit gaps_in, bit gaps_out,
                             bit squeeze, int n_items);
        int target;
        set_rules(rules, len);
        idle_in  = gaps_in;
        idle_out = gaps_out;
        hold_arm = squeeze;
        target   = items_made + n_items;
        while (items_made < target)
            gen_line();
        drain();
        hold_arm = 1'b0;
    endtask

    // main sequence
    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // registers come up with their defaults
        apb_check(ADDR_RULE, {31'd0, qts_pkg::RULE_SET_RESET});
        apb_check(ADDR_LEN, {16'd0, qts_pkg::MAX_LEN_RESET});

        // directed: escape-aware rules at reset settings
        queue_item("a", 1'b0);        // embedded section keeps a comma
        queue_item(qts_pkg::CH_QUOTE, 1'b0);
        queue_item(qts_pkg::CH_COMMA, 1'b0);
        queue_item(qts_pkg::CH_QUOTE, 1'b0);
        queue_item(qts_pkg::CH_SEMI, 1'b0);
        queue_item(qts_pkg::CH_QUOTE, 1'b0);   // escaped quote inside a quoted token
        queue_item(qts_pkg::CH_BSLASH, 1'b0);
        queue_item(qts_pkg::CH_QUOTE, 1'b0);
        queue_item(qts_pkg::CH_QUOTE, 1'b0);
        queue_item(qts_pkg::CH_QUOTE, 1'b0);   // empty quoted token
        queue_item(qts_pkg::CH_QUOTE, 1'b0);
        queue_item(8'hFF, 1'b0);      // extreme characters
        queue_item(8'h01, 1'b0);
        queue_item(qts_pkg::CH_CR, 1'b0);
        queue_item(qts_pkg::CH_QUOTE, 1'b0);   // open quote flushed by the line end
        queue_item(8'h00, 1'b1);
        queue_item("z", 1'b0);        // zero ends the data, rest ignored
        queue_item(8'h00, 1'b0);
        queue_item("q", 1'b0);
        queue_item(8'hA5, 1'b1);
        queue_item("m", 1'b0);        // left inside an embedded section
        queue_item(qts_pkg::CH_QUOTE, 1'b0);
        queue_item("n", 1'b0);
        drain();

        // switch to plain rules mid-token, length limit of 1
        set_rules(1'b1, 16'd1);
        queue_item(qts_pkg::CH_SPACE, 1'b0);
        queue_item(qts_pkg::CH_QUOTE, 1'b0);
        queue_item(qts_pkg::CH_BSLASH, 1'b0);
        queue_item(qts_pkg::CH_QUOTE, 1'b0);
        queue_item(8'h5A, 1'b1);
        drain();

        // random lines over a range of settings
        run_phase(1'b1, 16'd0, 1'b1, 1'b1, 1'b0, PHASE_ITEMS);
        run_phase(1'b0, 16'd256, 1'b0, 1'b1, 1'b1, PHASE_ITEMS);
        run_phase(1'b1, 16'd3, 1'b0, 1'b0, 1'b0, PHASE_ITEMS);
        run_phase(1'b0, 16'd1, 1'b1, 1'b0, 1'b0, PHASE_ITEMS);
        run_phase(1'b1, 16'($urandom_range(2, 8)), 1'b0, 1'b1, 1'b0, PHASE_ITEMS);
        run_phase(1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b0, PHASE_ITEMS);
        run_phase(1'b1, 16'($urandom_range(1, 12)), 1'b1, 1'b1, 1'b0, PHASE_ITEMS);

        // one token longer than the default length limit
        set_rules(1'b1, qts_pkg::MAX_LEN_RESET);
        idle_in  = 1'b0;
        idle_out = 1'b0;
        repeat (LONG_TOKEN) queue_item(word_char(), 1'b0);
        queue_item(8'h00, 1'b1);
        drain();

        $display("Run covered %0d input items and %0d result items", items_in, chars_out);
        $display("over %0d register settings, both rule sets and length limits 0 to 65535",
                 settings);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, tokens_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
